>>> rtl/cea_pkg.sv
// Shared types, constants and arithmetic helpers for the complex element-wise ALU.
package cea_pkg;

	localparam int DW        = 16;
	localparam int FW        = 12;
	localparam int PW        = 2 * DW;
	localparam int QW        = DW + 1;
	localparam int SQ_STEPS  = DW;
	localparam int DIV_STEPS = QW;

	localparam logic [2:0] FN_MULREAL = 3'd0;
	localparam logic [2:0] FN_MULCPLX = 3'd1;
	localparam logic [2:0] FN_DIVREAL = 3'd2;
	localparam logic [2:0] FN_DIVCPLX = 3'd3;
	localparam logic [2:0] FN_SQMAG   = 3'd4;
	localparam logic [2:0] FN_MAG     = 3'd5;
	localparam logic [2:0] FN_CONJ    = 3'd6;

	typedef struct packed {
		logic              sat;
		logic [DW-1:0]     val;
	} sat_t;

	// Products stage.
	typedef struct packed {
		logic [2:0]        func;
		logic              last;
		logic [DW-1:0]     ar;
		logic [DW-1:0]     ai;
		logic [DW-1:0]     br;
		logic [PW-1:0]     p_rr;
		logic [PW-1:0]     p_ii;
		logic [PW-1:0]     p_ri;
		logic [PW-1:0]     p_ir;
		logic [PW-1:0]     p_aa;
		logic [PW-1:0]     p_ai2;
		logic [PW-1:0]     p_bb;
		logic [PW-1:0]     p_bi2;
	} prod_t;

	// Item state carried through the divider and square root steps.
	typedef struct packed {
		logic [2:0]        func;
		logic              last;
		logic              dbz;
		logic              pre_sat;
		logic [DW-1:0]     pre_re;
		logic [DW-1:0]     pre_im;
		logic              neg_re;
		logic              neg_im;
		logic              ovf_re;
		logic              ovf_im;
		logic [PW-1:0]     den;
		logic [PW-1:0]     rem_re;
		logic [PW-1:0]     rem_im;
		logic [QW-1:0]     lo_re;
		logic [QW-1:0]     lo_im;
		logic [QW-1:0]     q_re;
		logic [QW-1:0]     q_im;
		logic [PW-1:0]     sx;
		logic [DW+1:0]     srem;
		logic [DW-1:0]     sroot;
	} item_t;

	typedef struct packed {
		logic [DW-1:0]     re;
		logic [DW-1:0]     im;
		logic              dbz;
		logic              sat;
		logic              last;
	} res_t;

	// Saturate a signed value to the data range.
	function automatic sat_t sat_signed(input logic signed [PW+1:0] v);
		sat_t r;
		if (v > $signed((PW+2)'((1 << (DW-1)) - 1))) begin
			r.sat = 1'b1;
			r.val = {1'b0, {(DW-1){1'b1}}};
		end else if (v < -$signed((PW+2)'(1 << (DW-1)))) begin
			r.sat = 1'b1;
			r.val = {1'b1, {(DW-1){1'b0}}};
		end else begin
			r.sat = 1'b0;
			r.val = v[DW-1:0];
		end
		return r;
	endfunction

	// Apply a sign to a magnitude and saturate.
	function automatic sat_t clip_mag(input logic neg, input logic [QW:0] v);
		sat_t r;
		logic [QW:0] nv;
		nv = ~v + (QW+1)'(1);
		if (!neg) begin
			r.sat = (v > (QW+1)'((1 << (DW-1)) - 1));
			r.val = r.sat ? {1'b0, {(DW-1){1'b1}}} : v[DW-1:0];
		end else begin
			r.sat = (v > (QW+1)'(1 << (DW-1)));
			r.val = r.sat ? {1'b1, {(DW-1){1'b0}}} : nv[DW-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/cea_prod.sv
// First pipeline stage: all operand products of one request.
module cea_prod (
	input  logic                clk,
	input  logic                en,
	input  logic [2:0]          func,
	input  logic                last,
	input  logic [cea_pkg::DW-1:0] ar,
	input  logic [cea_pkg::DW-1:0] ai,
	input  logic [cea_pkg::DW-1:0] br,
	input  logic [cea_pkg::DW-1:0] bi,
	output cea_pkg::prod_t      prod_s1
);
	import cea_pkg::*;

	logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir, m_aa, m_ai2, m_bb, m_bi2;

	// Full width signed products.
	always_comb begin
		m_rr  = $signed(ar) * $signed(br);
		m_ii  = $signed(ai) * $signed(bi);
		m_ri  = $signed(ar) * $signed(bi);
		m_ir  = $signed(ai) * $signed(br);
		m_aa  = $signed(ar) * $signed(ar);
		m_ai2 = $signed(ai) * $signed(ai);
		m_bb  = $signed(br) * $signed(br);
		m_bi2 = $signed(bi) * $signed(bi);
	end

	// Signed products, registered.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.func  <= func;
			prod_s1.last  <= last;
			prod_s1.ar    <= ar;
			prod_s1.ai    <= ai;
			prod_s1.br    <= br;
			prod_s1.p_rr  <= m_rr;
			prod_s1.p_ii  <= m_ii;
			prod_s1.p_ri  <= m_ri;
			prod_s1.p_ir  <= m_ir;
			prod_s1.p_aa  <= m_aa;
			prod_s1.p_ai2 <= m_ai2;
			prod_s1.p_bb  <= m_bb;
			prod_s1.p_bi2 <= m_bi2;
		end
	end

endmodule

>>> rtl/cea_setup.sv
// Second pipeline stage: sums, direct results and divider/root setup.
module cea_setup (
	input  logic                clk,
	input  logic                en,
	input  cea_pkg::prod_t      prod,
	output cea_pkg::item_t      item_s2
);
	import cea_pkg::*;

	logic signed [PW+1:0] s_mre, s_mim, s_dre, s_dim, e_rr, e_ir;
	logic [PW-1:0]        mag2, den, num_re, num_im;
	logic [PW+FW-1:0]     n_re, n_im;
	logic                 neg_re, neg_im, is_div;
	sat_t                 r_re, r_im, r_sq, r_cj;
	logic [DW-1:0]        conj_im;

	always_comb begin
		e_rr  = {{2{prod.p_rr[PW-1]}}, prod.p_rr};
		e_ir  = {{2{prod.p_ir[PW-1]}}, prod.p_ir};
		s_mre = e_rr - {{2{prod.p_ii[PW-1]}}, prod.p_ii};
		s_mim = {{2{prod.p_ri[PW-1]}}, prod.p_ri} + e_ir;
		s_dre = e_rr + {{2{prod.p_ii[PW-1]}}, prod.p_ii};
		s_dim = e_ir - {{2{prod.p_ri[PW-1]}}, prod.p_ri};
		mag2  = prod.p_aa + prod.p_ai2;

		// Products floored to the fraction width, then saturated.
		if (prod.func == FN_MULREAL) begin
			r_re = sat_signed(e_rr >>> FW);
			r_im = sat_signed(e_ir >>> FW);
		end else begin
			r_re = sat_signed(s_mre >>> FW);
			r_im = sat_signed(s_mim >>> FW);
		end
		r_sq.sat = (mag2[PW-1:FW] > (PW-FW)'((1 << (DW-1)) - 1));
		r_sq.val = r_sq.sat ? {1'b0, {(DW-1){1'b1}}} : mag2[FW+DW-1:FW];
		conj_im   = ~prod.ai + DW'(1);
		r_cj.sat  = (prod.ai == {1'b1, {(DW-1){1'b0}}});
		r_cj.val  = r_cj.sat ? {1'b0, {(DW-1){1'b1}}} : conj_im;

		// Divider operands as sign and magnitude.
		if (prod.func == FN_DIVREAL) begin
			num_re = PW'(prod.ar[DW-1] ? DW'(~prod.ar + DW'(1)) : prod.ar);
			num_im = PW'(prod.ai[DW-1] ? DW'(~prod.ai + DW'(1)) : prod.ai);
			den    = PW'(prod.br[DW-1] ? DW'(~prod.br + DW'(1)) : prod.br);
			neg_re = prod.ar[DW-1] ^ prod.br[DW-1];
			neg_im = prod.ai[DW-1] ^ prod.br[DW-1];
		end else begin
			num_re = PW'(s_dre[PW+1] ? -s_dre : s_dre);
			num_im = PW'(s_dim[PW+1] ? -s_dim : s_dim);
			den    = prod.p_bb + prod.p_bi2;
			neg_re = s_dre[PW+1];
			neg_im = s_dim[PW+1];
		end
		n_re   = {num_re, {FW{1'b0}}};
		n_im   = {num_im, {FW{1'b0}}};
		is_div = (prod.func == FN_DIVREAL) || (prod.func == FN_DIVCPLX);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.func   <= prod.func;
			item_s2.last   <= prod.last;
			item_s2.dbz    <= is_div && (den == '0);
			item_s2.neg_re <= neg_re;
			item_s2.neg_im <= neg_im;
			item_s2.ovf_re <= (PW'(n_re[PW+FW-1:QW]) >= den);
			item_s2.ovf_im <= (PW'(n_im[PW+FW-1:QW]) >= den);
			item_s2.den    <= den;
			item_s2.rem_re <= PW'(n_re[PW+FW-1:QW]);
			item_s2.rem_im <= PW'(n_im[PW+FW-1:QW]);
			item_s2.lo_re  <= n_re[QW-1:0];
			item_s2.lo_im  <= n_im[QW-1:0];
			item_s2.q_re   <= '0;
			item_s2.q_im   <= '0;
			item_s2.sx     <= mag2;
			item_s2.srem   <= '0;
			item_s2.sroot  <= '0;
			case (prod.func)
				FN_MULREAL, FN_MULCPLX: begin
					item_s2.pre_re  <= r_re.val;
					item_s2.pre_im  <= r_im.val;
					item_s2.pre_sat <= r_re.sat | r_im.sat;
				end
				FN_SQMAG: begin
					item_s2.pre_re  <= r_sq.val;
					item_s2.pre_im  <= '0;
					item_s2.pre_sat <= r_sq.sat;
				end
				FN_CONJ: begin
					item_s2.pre_re  <= prod.ar;
					item_s2.pre_im  <= r_cj.val;
					item_s2.pre_sat <= r_cj.sat;
				end
				default: begin
					item_s2.pre_re  <= '0;
					item_s2.pre_im  <= '0;
					item_s2.pre_sat <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> rtl/cea_step.sv
// One restoring step of both dividers and, where enabled, of the square root.
module cea_step (
	input  logic                clk,
	input  logic                en,
	input  logic                sqrt_on,
	input  cea_pkg::item_t      item,
	output cea_pkg::item_t      step_s
);
	import cea_pkg::*;

	logic [PW:0]   t_re, t_im, d_ext;
	logic          b_re, b_im;
	logic [DW+3:0] sr, trial;
	logic          b_sq;
	item_t         nx;

	always_comb begin
		nx    = item;
		d_ext = {1'b0, item.den};

		// Quotient bit for each component.
		t_re = {item.rem_re, item.lo_re[QW-1]};
		t_im = {item.rem_im, item.lo_im[QW-1]};
		b_re = (t_re >= d_ext);
		b_im = (t_im >= d_ext);
		nx.rem_re = b_re ? PW'(t_re - d_ext) : t_re[PW-1:0];
		nx.rem_im = b_im ? PW'(t_im - d_ext) : t_im[PW-1:0];
		nx.lo_re  = {item.lo_re[QW-2:0], 1'b0};
		nx.lo_im  = {item.lo_im[QW-2:0], 1'b0};
		nx.q_re   = {item.q_re[QW-2:0], b_re};
		nx.q_im   = {item.q_im[QW-2:0], b_im};

		// Root bit from the next two radicand bits.
		sr    = {item.srem, item.sx[PW-1:PW-2]};
		trial = {2'b00, item.sroot, 2'b01};
		b_sq  = (sr >= trial);
		if (sqrt_on) begin
			nx.srem  = b_sq ? (DW+2)'(sr - trial) : sr[DW+1:0];
			nx.sroot = {item.sroot[DW-2:0], b_sq};
			nx.sx    = {item.sx[PW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s <= nx;
		end
	end

endmodule

>>> rtl/cea_out.sv
// Last pipeline stage: result selection and saturation into the output register.
module cea_out (
	input  logic                clk,
	input  logic                en,
	input  cea_pkg::item_t      item,
	output cea_pkg::res_t       res_s20
);
	import cea_pkg::*;

	sat_t d_re, d_im, m_r;
	res_t nx;

	always_comb begin
		d_re = clip_mag(item.neg_re, {item.ovf_re, item.q_re});
		d_im = clip_mag(item.neg_im, {item.ovf_im, item.q_im});
		m_r  = clip_mag(1'b0, (QW+1)'(item.sroot));
		nx.last = item.last;
		nx.dbz  = 1'b0;
		case (item.func)
			FN_DIVREAL, FN_DIVCPLX: begin
				if (item.dbz) begin
					nx.re  = '0;
					nx.im  = '0;
					nx.dbz = 1'b1;
					nx.sat = 1'b0;
				end else begin
					nx.re  = d_re.val;
					nx.im  = d_im.val;
					nx.sat = d_re.sat | d_im.sat;
				end
			end
			FN_MAG: begin
				nx.re  = m_r.val;
				nx.im  = '0;
				nx.sat = m_r.sat;
			end
			default: begin
				nx.re  = item.pre_re;
				nx.im  = item.pre_im;
				nx.sat = item.pre_sat;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s20 <= nx;
		end
	end

endmodule

>>> rtl/complex_elementwise_alu.sv
// Top level of the complex element-wise ALU: a twenty stage pipeline.
//
// Input channel: in_valid/in_ready carry one request (func, a_re, a_im, b_re,
// b_im, last_in). Output channel: out_valid/out_ready carry one result
// (res_re, res_im, div_by_zero, saturated, last_out) for every request, in order.
// The pipeline has twenty register stages: one of products, one of sums and
// setup, seventeen restoring steps shared by the two dividers and the sixteen
// bit square root, and the output register. A result is valid once it reaches
// the output register and can be taken at the following edge. Without stalls,
// throughput is one request per cycle; the seventeen quotient bits, one per
// stage, set the depth. Every stage holds a valid bit, and a stage loads
// whenever it is empty or the stage after it moves, so bubbles close up.
// When the receiver stalls, the output register holds its result and the
// stages behind it keep filling; in_ready falls only when every stage is full.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module complex_elementwise_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic signed [cea_pkg::DW-1:0] a_re,
	input  logic signed [cea_pkg::DW-1:0] a_im,
	input  logic signed [cea_pkg::DW-1:0] b_re,
	input  logic signed [cea_pkg::DW-1:0] b_im,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [cea_pkg::DW-1:0] res_re,
	output logic signed [cea_pkg::DW-1:0] res_im,
	output logic        div_by_zero,
	output logic        saturated,
	output logic        last_out
);
	import cea_pkg::*;

	localparam int NSTG = DIV_STEPS + 3;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;
	prod_t           prod_s1;
	item_t           stg [0:DIV_STEPS];
	res_t            res_s20;

	// Load enables ripple back from the output.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	cea_prod u_prod (
		.clk     (clk),
		.en      (en[0]),
		.func    (func),
		.last    (last_in),
		.ar      (a_re),
		.ai      (a_im),
		.br      (b_re),
		.bi      (b_im),
		.prod_s1 (prod_s1)
	);

	cea_setup u_setup (
		.clk     (clk),
		.en      (en[1]),
		.prod    (prod_s1),
		.item_s2 (stg[0])
	);

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		cea_step u_step (
			.clk     (clk),
			.en      (en[k+2]),
			.sqrt_on ((k < SQ_STEPS) ? 1'b1 : 1'b0),
			.item    (stg[k]),
			.step_s  (stg[k+1])
		);
	end

	cea_out u_out (
		.clk     (clk),
		.en      (en[NSTG-1]),
		.item    (stg[DIV_STEPS]),
		.res_s20 (res_s20)
	);

	assign in_ready    = en[0];
	assign out_valid   = vld_q[NSTG-1];
	assign res_re      = res_s20.re;
	assign res_im      = res_s20.im;
	assign div_by_zero = res_s20.dbz;
	assign saturated   = res_s20.sat;
	assign last_out    = res_s20.last;

endmodule

>>> sim/complex_elementwise_alu_test.sv
// Testbench for the complex element-wise ALU: random and directed requests checked against a predictor.
module complex_elementwise_alu_test;
	import cea_pkg::*;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		logic        dbz;
		logic        sat;
		logic        last;
	} alu_result_t;

	// Scoreboard: predicts each result from its request and checks results in order.
	class alu_scoreboard;
		alu_result_t pending[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		// Floor a signed product sum by the fraction bits and saturate.
		static function logic [15:0] floor_clip(longint v, ref bit sat);
			longint f;
			f = v >>> FW;
			if (f > 32767) begin
				sat = 1;
				f = 32767;
			end else if (f < -32768) begin
				sat = 1;
				f = -32768;
			end
			return f[15:0];
		endfunction

		// Truncating fixed-point divide with saturation.
		static function logic [15:0] quot_clip(longint num, longint den, ref bit sat);
			bit     neg;
			longint q;
			longint un;
			longint ud;
			neg = (num < 0) != (den < 0);
			un = (num < 0) ? -num : num;
			ud = (den < 0) ? -den : den;
			q = un / ud;
			if (q > 65536)
				q = 65536;
			else
				q = (un << FW) / ud;
			if (neg) q = -q;
			if (q > 32767) begin
				sat = 1;
				q = 32767;
			end else if (q < -32768) begin
				sat = 1;
				q = -32768;
			end
			return q[15:0];
		endfunction

		static function longint int_sqrt(longint x);
			longint r;
			longint b;
			r = 0;
			for (b = longint'(1) << 31; b > 0; b = b >> 1)
				if ((r + b) * (r + b) <= x)
					r = r + b;
			return r;
		endfunction

		function void note_request(logic [2:0] fn, logic signed [15:0] ar, logic signed [15:0] ai,
				logic signed [15:0] br, logic signed [15:0] bi, logic last);
			alu_result_t e;
			bit          sat;
			longint      n;
			longint      s;
			sat = 0;
			e.re = 0;
			e.im = 0;
			e.dbz = 0;
			e.last = last;
			case (fn)
				FN_MULREAL: begin
					e.re = floor_clip(longint'(ar) * br, sat);
					e.im = floor_clip(longint'(ai) * br, sat);
				end
				FN_MULCPLX: begin
					e.re = floor_clip(longint'(ar) * br - longint'(ai) * bi, sat);
					e.im = floor_clip(longint'(ar) * bi + longint'(ai) * br, sat);
				end
				FN_DIVREAL: begin
					if (br == 0) e.dbz = 1;
					else begin
						e.re = quot_clip(ar, br, sat);
						e.im = quot_clip(ai, br, sat);
					end
				end
				FN_DIVCPLX: begin
					n = longint'(br) * br + longint'(bi) * bi;
					if (n == 0) e.dbz = 1;
					else begin
						e.re = quot_clip(longint'(ar) * br + longint'(ai) * bi, n, sat);
						e.im = quot_clip(longint'(ai) * br - longint'(ar) * bi, n, sat);
					end
				end
				FN_SQMAG: begin
					e.re = floor_clip(longint'(ar) * ar + longint'(ai) * ai, sat);
				end
				FN_MAG: begin
					s = int_sqrt(longint'(ar) * ar + longint'(ai) * ai);
					if (s > 32767) begin
						sat = 1;
						s = 32767;
					end
					e.re = s[15:0];
				end
				FN_CONJ: begin
					e.re = ar;
					if (ai == -32768) begin
						sat = 1;
						e.im = 16'h7fff;
					end else
						e.im = -ai;
				end
				default: ;
			endcase
			e.sat = sat;
			pending.push_back(e);
		endfunction

		function void check_result(logic [15:0] re, logic [15:0] im, logic dbz, logic sat,
				logic last);
			alu_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h", $time, re, im);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (re !== e.re) begin
				$display("%0t: res_re expected %h actual %h", $time, e.re, re);
				errors++;
			end
			if (im !== e.im) begin
				$display("%0t: res_im expected %h actual %h", $time, e.im, im);
				errors++;
			end
			if (dbz !== e.dbz) begin
				$display("%0t: div_by_zero expected %b actual %b", $time, e.dbz, dbz);
				errors++;
			end
			if (sat !== e.sat) begin
				$display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last_out expected %b actual %b", $time, e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] func;
	logic signed [15:0] a_re;
	logic signed [15:0] a_im;
	logic signed [15:0] b_re;
	logic signed [15:0] b_im;
	logic last_in;
	logic out_valid;
	logic out_ready;
	logic signed [15:0] res_re;
	logic signed [15:0] res_im;
	logic div_by_zero;
	logic saturated;
	logic last_out;

	alu_scoreboard scb;
	bit            rx_steady;
	longint        cycles;

	complex_elementwise_alu i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Pick a data value biased toward the edges of the range.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 8)) - 4);
			4: return 16'(int'($urandom_range(0, 16383)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	// Send one request, after a random gap when gap is set; valid stays high between
	// requests that follow with no gap.
	task automatic send_request(logic [2:0] fn, logic [15:0] ar, logic [15:0] ai,
			logic [15:0] br, logic [15:0] bi, logic last, bit gap);
		int idle;
		idle = gap ? int'($urandom_range(0, 19)) : 0;
		if (idle > 0) begin
			in_valid <= 0;
			repeat (idle) @(negedge clk);
		end
		in_valid <= 1;
		func <= fn;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		last_in <= last;
		do @(posedge clk); while (!in_ready);
		scb.note_request(fn, ar, ai, br, bi, last);
		@(negedge clk);
	endtask

	// Receiver: random stall before each result, with steady stretches.
	initial begin
		int idle;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			idle = rx_steady ? 0 : int'($urandom_range(0, 19));
			if (idle > 0) begin
				out_ready <= 0;
				repeat (idle) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			scb.check_result(res_re, res_im, div_by_zero, saturated, last_out);
		end
	end

	// Run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] ext[4];
		bit          gap;
		scb = new();
		rx_steady = 0;
		arst_n = 0;
		in_valid = 0;
		func = 0;
		a_re = 0;
		a_im = 0;
		b_re = 0;
		b_im = 0;
		last_in = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001};
		// Directed: every operation on extremes, zero divisors, conjugate of most negative.
		for (int f = 0; f < 8; f++) begin
			send_request(3'(f), ext[0], ext[0], ext[0], ext[1], 1'b0, 1'b0);
			send_request(3'(f), ext[1], ext[1], ext[2], ext[2], 1'b1, 1'b0);
			send_request(3'(f), ext[1], ext[0], ext[3], ext[0], 1'b0, 1'b1);
		end
		// Random requests with gap-free stretches.
		for (int i = 0; i < 1200; i++) begin
			if (i % 200 == 0) rx_steady = ($urandom_range(0, 2) == 0);
			gap = (i % 300) >= 60;
			send_request(3'($urandom_range(0, 7)), pick_value(), pick_value(), pick_value(),
				pick_value(), 1'($urandom_range(0, 1)), gap);
		end
		in_valid <= 0;
		while (scb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (scb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

>>> sim.f
rtl/cea_pkg.sv
rtl/cea_prod.sv
rtl/cea_setup.sv
rtl/cea_step.sv
rtl/cea_out.sv
rtl/complex_elementwise_alu.sv
sim/complex_elementwise_alu_test.sv
